>>> hdl/gtl_pkg.sv
package gtl_pkg;

  typedef enum logic [2:0] {
    HELD_NONE,
    HELD_M,
    HELD_N,
    HELD_SM,
    HELD_SN
  } held_e;

  // character codes
  localparam logic [7:0] CODE_UP_MU  = 8'd204;
  localparam logic [7:0] CODE_UP_NU  = 8'd205;
  localparam logic [7:0] CODE_LO_MU  = 8'd236;
  localparam logic [7:0] CODE_LO_NU  = 8'd237;
  localparam logic [7:0] CODE_UP_PI  = 8'd208;
  localparam logic [7:0] CODE_LO_PI  = 8'd240;
  localparam logic [7:0] CODE_UP_TAU = 8'd212;
  localparam logic [7:0] CODE_LO_TAU = 8'd244;

  localparam logic [7:0] CH_APOS  = 8'd39;
  localparam logic [7:0] CH_QUOTE = 8'd34;

  localparam int unsigned RUN_MAX = 4;

  // one run of up to four output characters, chars[0] goes out first
  typedef struct packed {
    logic [2:0]               len;
    logic [RUN_MAX-1:0][7:0]  chars;
  } run_t;

  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][7:0] chars;
  } xlat_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } runq_head_t;

  function automatic logic [7:0] upper_letter(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:  ch = "A";
      5'd1:  ch = "V";
      5'd2:  ch = "G";
      5'd3:  ch = "D";
      5'd4:  ch = "E";
      5'd5:  ch = "Z";
      5'd6:  ch = "H";
      5'd7:  ch = "8";
      5'd8:  ch = "I";
      5'd9:  ch = "K";
      5'd10: ch = "L";
      5'd11: ch = "M";
      5'd12: ch = "N";
      5'd13: ch = "K";
      5'd14: ch = "O";
      5'd15: ch = "P";
      5'd16: ch = "R";
      5'd17: ch = "S";
      5'd18: ch = "T";
      5'd19: ch = "Y";
      5'd20: ch = "F";
      5'd21: ch = "X";
      5'd22: ch = "P";
      5'd23: ch = "W";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] lower_letter(input logic [4:0] idx);
    logic [7:0] up;
    up = upper_letter(idx);
    return (up == "8") ? up : (up | 8'h20);
  endfunction

  function automatic logic [7:0] held_char(input held_e h);
    logic [7:0] ch;
    case (h)
      HELD_M:  ch = "M";
      HELD_N:  ch = "N";
      HELD_SM: ch = "m";
      HELD_SN: ch = "n";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic held_e hold_code(input logic [7:0] c);
    held_e h;
    case (c)
      CODE_UP_MU: h = HELD_M;
      CODE_UP_NU: h = HELD_N;
      CODE_LO_MU: h = HELD_SM;
      CODE_LO_NU: h = HELD_SN;
      default:    h = HELD_NONE;
    endcase
    return h;
  endfunction

  function automatic xlat_t xlat(input logic [7:0] c);
    xlat_t      x;
    logic [7:0] off;
    x.len   = 2'd1;
    x.chars = '0;
    x.chars[0] = c;
    off = 8'd0;
    if (c >= 8'd193 && c <= 8'd209) begin
      off = c - 8'd193;
      x.chars[0] = upper_letter(off[4:0]);
    end else if (c >= 8'd211 && c <= 8'd217) begin
      off = c - 8'd194;
      x.chars[0] = upper_letter(off[4:0]);
    end else if (c >= 8'd225 && c <= 8'd241) begin
      off = c - 8'd225;
      x.chars[0] = lower_letter(off[4:0]);
    end else if (c == 8'd242) begin
      x.chars[0] = "s";
    end else if (c >= 8'd243 && c <= 8'd249) begin
      off = c - 8'd226;
      x.chars[0] = lower_letter(off[4:0]);
    end

    // xi and psi take a trailing s
    if (c == 8'd206 || c == 8'd216) begin
      x.chars[1] = "S";
      x.len = 2'd2;
    end
    if (c == 8'd238 || c == 8'd248) begin
      x.chars[1] = "s";
      x.len = 2'd2;
    end

    case (c)
      8'd182: begin x.chars[0] = CH_APOS; x.chars[1] = "A"; x.len = 2'd2; end
      8'd184: begin x.chars[0] = CH_APOS; x.chars[1] = "E"; x.len = 2'd2; end
      8'd185: begin x.chars[0] = CH_APOS; x.chars[1] = "H"; x.len = 2'd2; end
      8'd186: begin x.chars[0] = CH_APOS; x.chars[1] = "I"; x.len = 2'd2; end
      8'd188: begin x.chars[0] = CH_APOS; x.chars[1] = "O"; x.len = 2'd2; end
      8'd190: begin x.chars[0] = CH_APOS; x.chars[1] = "Y"; x.len = 2'd2; end
      8'd191: begin x.chars[0] = CH_APOS; x.chars[1] = "W"; x.len = 2'd2; end
      8'd192: begin
        x.chars[0] = "i"; x.chars[1] = CH_APOS; x.chars[2] = CH_QUOTE; x.len = 2'd3;
      end
      8'd218: begin x.chars[0] = "I"; x.chars[1] = CH_QUOTE; x.len = 2'd2; end
      8'd219: begin x.chars[0] = "Y"; x.chars[1] = CH_QUOTE; x.len = 2'd2; end
      8'd220: begin x.chars[0] = "a"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd221: begin x.chars[0] = "e"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd222: begin x.chars[0] = "h"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd223: begin x.chars[0] = "i"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd224: begin
        x.chars[0] = "y"; x.chars[1] = CH_APOS; x.chars[2] = CH_QUOTE; x.len = 2'd3;
      end
      8'd250: begin x.chars[0] = "i"; x.chars[1] = CH_QUOTE; x.len = 2'd2; end
      8'd251: begin x.chars[0] = "y"; x.chars[1] = CH_QUOTE; x.len = 2'd2; end
      8'd252: begin x.chars[0] = "o"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd253: begin x.chars[0] = "y"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      8'd254: begin x.chars[0] = "w"; x.chars[1] = CH_APOS; x.len = 2'd2; end
      default: ;
    endcase
    return x;
  endfunction

endpackage

>>> hdl/greek_to_latin_transliterator.sv
// a byte's run is written into the run queue, then its first character is loaded into the output register
// throughput: one byte accepted per cycle while the run queue has room
// output side: one character per cycle while the receiver pops, so a run of n characters
//   takes n output transactions; the run queue depth sets how far input runs ahead
// reset: asynchronous, active low; clears the held letter, queue and output valid
module greek_to_latin_transliterator import gtl_pkg::*; #(
  parameter int unsigned RUNQ_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input side, queue style
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  // result side, queue style
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);

  logic       accept;
  logic       run_push;
  run_t       run;
  runq_head_t head;
  logic       head_pop;

  // an input transaction completes whenever the run queue is not full;
  // inputs that only set a held letter push nothing
  assign accept = push && !full;

  // front: held letter tracking and per-byte run building
  gtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .eos_i      (end_of_stream_i),
    .run_push_o (run_push),
    .run_o      (run)
  );

  // short queue of whole runs decouples the front from the serializer
  gtl_runq #(
    .DEPTH (RUNQ_DEPTH)
  ) u_runq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (run_push),
    .run_i  (run),
    .pop_i  (head_pop),
    .full_o (full),
    .head_o (head)
  );

  // back: walks the head run one character per output transaction
  gtl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_pop_o (head_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o)
  );

endmodule

>>> hdl/gtl_front.sv
module gtl_front import gtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       eos_i,
  output logic       run_push_o,
  output run_t       run_o
);

  held_e held_q, held_d;
  run_t  run;
  xlat_t x;
  held_e nxt;
  logic  pair_mb, pair_nd, pre;

  always_comb begin
    x       = xlat(in_byte_i);
    nxt     = hold_code(in_byte_i);
    pre     = (held_q != HELD_NONE);
    pair_mb = (held_q == HELD_M || held_q == HELD_SM) &&
              (in_byte_i == CODE_UP_PI || in_byte_i == CODE_LO_PI);
    pair_nd = (held_q == HELD_N || held_q == HELD_SN) &&
              (in_byte_i == CODE_UP_TAU || in_byte_i == CODE_LO_TAU);
    run     = '0;
    held_d  = HELD_NONE;

    if (pair_mb) begin
      run.len      = 3'd1;
      run.chars[0] = (held_q == HELD_SM && in_byte_i == CODE_LO_PI) ? 8'("b") : 8'("B");
    end else if (pair_nd) begin
      run.len      = 3'd1;
      run.chars[0] = (held_q == HELD_SN && in_byte_i == CODE_LO_TAU) ? 8'("d") : 8'("D");
    end else if (nxt == HELD_NONE) begin
      // plain byte, held letter (if any) goes out first
      if (pre) begin
        run.len   = {1'b0, x.len} + 3'd1;
        run.chars = {x.chars, held_char(held_q)};
      end else begin
        run.len   = {1'b0, x.len};
        run.chars = {8'd0, x.chars};
      end
    end else begin
      // new letter to hold; end of stream releases it right away
      if (pre) begin
        run.chars[0] = held_char(held_q);
        if (eos_i) begin
          run.chars[1] = held_char(nxt);
          run.len      = 3'd2;
        end else begin
          run.len = 3'd1;
          held_d  = nxt;
        end
      end else if (eos_i) begin
        run.chars[0] = held_char(nxt);
        run.len      = 3'd1;
      end else begin
        held_d = nxt;
      end
    end
  end

  assign run_o      = run;
  assign run_push_o = accept_i && (run.len != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= HELD_NONE;
    end else if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

>>> hdl/gtl_runq.sv
module gtl_runq import gtl_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  run_t       run_i,
  input  logic       pop_i,
  output logic       full_o,
  output runq_head_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  run_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign do_push = push_i && (cnt_q != CntFull);
  assign do_pop  = pop_i && (cnt_q != '0);

  assign full_o       = (cnt_q == CntFull);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.run   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/gtl_back.sv
module gtl_back import gtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  runq_head_t head_i,
  output logic       head_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;
  logic       load, is_last;

  assign load       = head_i.valid && (!valid_q || pop_i);
  assign is_last    = ({1'b0, idx_q} == (head_i.run.len - 3'd1));
  assign head_pop_o = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.run.chars[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign empty_o    = !valid_q;
  assign out_char_o = char_q;
  assign run_last_o = last_q;

endmodule

>>> tb/sv/gtl_transliteration_checker.sv
module gtl_transliteration_checker import gtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_char_i,
  input  logic       run_last_i,
  output int         mismatches_o,
  output int         chars_due_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } latin_char_t;

  // greek alphabet order, gaps (final sigma, unused codes) handled by the caller
  localparam logic [8*24-1:0] UPPER_ROW = "AVGDEZH8IKLMNKOPRSTYFXPW";
  localparam logic [8*24-1:0] LOWER_ROW = "avgdezh8iklmnkoprstyfxpw";

  held_e       held_q = HELD_NONE;
  latin_char_t latin_due [$];
  latin_char_t want;
  int          mismatch_total = 0;

  function automatic logic [7:0] row_char(input logic [8*24-1:0] row, input int idx);
    return row[8*(23-idx) +: 8];
  endfunction

  function automatic logic [7:0] held_letter_char(input held_e h);
    case (h)
      HELD_M:  return "M";
      HELD_N:  return "N";
      HELD_SM: return "m";
      HELD_SN: return "n";
      default: return 8'd0;
    endcase
  endfunction

  function automatic held_e held_from_code(input logic [7:0] c);
    case (c)
      CODE_UP_MU: return HELD_M;
      CODE_UP_NU: return HELD_N;
      CODE_LO_MU: return HELD_SM;
      CODE_LO_NU: return HELD_SN;
      default:    return HELD_NONE;
    endcase
  endfunction

  task automatic transliterate_byte(input logic [7:0] c, input logic eos);
    logic [7:0]      latin [$];
    logic [7:0]      base;
    logic [2:0][7:0] tail;
    int              cnt;
    held_e           nxt;
    logic            paired;
    paired = 1'b0;
    nxt    = HELD_NONE;
    if ((held_q == HELD_M || held_q == HELD_SM) && (c == CODE_UP_PI || c == CODE_LO_PI)) begin
      // mu + pi reads as b, lowercase only when both letters are
      latin.push_back((held_q == HELD_SM && c == CODE_LO_PI) ? "b" : "B");
      paired = 1'b1;
    end else if ((held_q == HELD_N || held_q == HELD_SN) &&
                 (c == CODE_UP_TAU || c == CODE_LO_TAU)) begin
      latin.push_back((held_q == HELD_SN && c == CODE_LO_TAU) ? "d" : "D");
      paired = 1'b1;
    end
    if (!paired) begin
      if (held_q != HELD_NONE) latin.push_back(held_letter_char(held_q));
      nxt = held_from_code(c);
      if (nxt == HELD_NONE) begin
        base = c;
        if (c >= 8'd193 && c <= 8'd209) base = row_char(UPPER_ROW, c - 8'd193);
        else if (c >= 8'd211 && c <= 8'd217) base = row_char(UPPER_ROW, c - 8'd194);
        else if (c >= 8'd225 && c <= 8'd241) base = row_char(LOWER_ROW, c - 8'd225);
        else if (c == 8'd242) base = "s";
        else if (c >= 8'd243 && c <= 8'd249) base = row_char(LOWER_ROW, c - 8'd226);
        // tail holds characters left to right, first one in the top byte
        cnt = 2;
        case (c)
          8'd182: tail = {CH_APOS, "A", 8'd0};
          8'd184: tail = {CH_APOS, "E", 8'd0};
          8'd185: tail = {CH_APOS, "H", 8'd0};
          8'd186: tail = {CH_APOS, "I", 8'd0};
          8'd188: tail = {CH_APOS, "O", 8'd0};
          8'd190: tail = {CH_APOS, "Y", 8'd0};
          8'd191: tail = {CH_APOS, "W", 8'd0};
          8'd192: begin tail = {"i", CH_APOS, CH_QUOTE}; cnt = 3; end
          8'd218: tail = {"I", CH_QUOTE, 8'd0};
          8'd219: tail = {"Y", CH_QUOTE, 8'd0};
          8'd220: tail = {"a", CH_APOS, 8'd0};
          8'd221: tail = {"e", CH_APOS, 8'd0};
          8'd222: tail = {"h", CH_APOS, 8'd0};
          8'd223: tail = {"i", CH_APOS, 8'd0};
          8'd224: begin tail = {"y", CH_APOS, CH_QUOTE}; cnt = 3; end
          8'd250: tail = {"i", CH_QUOTE, 8'd0};
          8'd251: tail = {"y", CH_QUOTE, 8'd0};
          8'd252: tail = {"o", CH_APOS, 8'd0};
          8'd253: tail = {"y", CH_APOS, 8'd0};
          8'd254: tail = {"w", CH_APOS, 8'd0};
          8'd206, 8'd216: tail = {base, "S", 8'd0};
          8'd238, 8'd248: tail = {base, "s", 8'd0};
          default: begin tail = {base, 8'd0, 8'd0}; cnt = 1; end
        endcase
        for (int i = 0; i < cnt; i++) latin.push_back(tail[2-i]);
      end
    end
    if (eos && nxt != HELD_NONE) begin
      latin.push_back(held_letter_char(nxt));
      nxt = HELD_NONE;
    end
    held_q = nxt;
    foreach (latin[i]) latin_due.push_back('{ch: latin[i], last: (i == latin.size() - 1)});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_i) transliterate_byte(in_byte_i, end_of_stream_i);
      if (pop_i && !empty_i) begin
        if (latin_due.size() == 0) begin
          $display("%0t: unexpected out_char %h run_last %b, nothing predicted",
                   $time, out_char_i, run_last_i);
          mismatch_total++;
        end else begin
          want = latin_due.pop_front();
          if (out_char_i !== want.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char_i);
            mismatch_total++;
          end
          if (run_last_i !== want.last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.last, run_last_i);
            mismatch_total++;
          end
        end
      end
    end
    mismatches_o <= mismatch_total;
    chars_due_o  <= latin_due.size();
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import gtl_pkg::*;

  // cycles with no transaction on either side before the run is declared hung
  localparam int STALL_LIMIT     = 2000;
  // long receiver hold-off so the run queue fills and input backs up
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AT     = 40;
  localparam int RANDOM_BYTES    = 260;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       eos;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       run_last;

  int mismatches;
  int chars_due;
  int idle_cycles = 0;
  int pops_seen   = 0;
  bit steady      = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  greek_to_latin_transliterator i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte),
    .end_of_stream_i (eos),
    .empty           (empty),
    .pop             (pop),
    .out_char_o      (out_char),
    .run_last_o      (run_last)
  );

  // watches both queue ports, predicts every character and compares
  gtl_transliteration_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push_i          (push),
    .full_i          (full),
    .in_byte_i       (in_byte),
    .end_of_stream_i (eos),
    .empty_i         (empty),
    .pop_i           (pop),
    .out_char_i      (out_char),
    .run_last_i      (run_last),
    .mismatches_o    (mismatches),
    .chars_due_o     (chars_due)
  );

  // gap length for either side: mostly none or short, now and then long;
  // while steady is set both sides run back to back
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offer one byte until the block takes it, then maybe idle a while;
  // with no gap push stays high and the next call only updates the payload
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    push    <= 1'b1;
    in_byte <= b;
    eos     <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: pop with random gaps, one long hold-off early in the run
  initial begin : result_drain
    int gap;
    pop = 1'b0;
    wait (rst_n);
    forever begin
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      pops_seen++;
      if (pops_seen == HOLD_OFF_AT) begin
        // sender keeps going meanwhile, so the block must stall its input
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // hang detection: any transaction on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : byte_source
    logic [7:0] b;
    logic       last;
    int         pick;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_byte = 8'd0;
    eos     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: byte extremes, plain letters, multi-character forms
    send_byte(8'd0, 1'b0);      // null byte passes straight through
    send_byte(8'd255, 1'b0);    // top code, unmapped
    send_byte(8'd193, 1'b0);    // first capital letter
    send_byte(8'd210, 1'b0);    // hole inside the capital range
    send_byte(8'd192, 1'b0);    // three characters
    send_byte(8'd224, 1'b0);
    send_byte(8'd238, 1'b0);    // lowercase xi, two letters
    send_byte(8'd242, 1'b0);    // final sigma
    // held letter pairings in several case mixes
    send_byte(CODE_UP_MU, 1'b0);  send_byte(CODE_UP_PI, 1'b0);
    send_byte(CODE_LO_MU, 1'b0);  send_byte(CODE_LO_PI, 1'b0);
    send_byte(CODE_LO_MU, 1'b0);  send_byte(CODE_UP_PI, 1'b0);
    send_byte(CODE_LO_NU, 1'b0);  send_byte(CODE_LO_TAU, 1'b0);
    send_byte(CODE_UP_NU, 1'b0);  send_byte(CODE_LO_TAU, 1'b0);
    // held letter replaced by another one, then released by a null byte
    send_byte(CODE_UP_MU, 1'b0);  send_byte(CODE_UP_NU, 1'b0);
    send_byte(CODE_LO_NU, 1'b0);  send_byte(8'd0, 1'b0);
    // end of stream: flush right away, pair on the last byte, and the
    // longest run (held letter plus a three character form)
    send_byte(CODE_LO_MU, 1'b1);
    send_byte(CODE_UP_NU, 1'b0);  send_byte(CODE_UP_TAU, 1'b1);
    send_byte(CODE_LO_NU, 1'b0);  send_byte(8'd192, 1'b1);

    // random: mostly greek text rich in mu/nu and pi/tau,
    // with some arbitrary bytes mixed in
    for (int k = 0; k < RANDOM_BYTES; k++) begin
      steady = (k >= 120 && k < 160);
      pick   = $urandom_range(0, 99);
      if (pick < 22) begin
        case ($urandom_range(0, 3))
          0:       b = CODE_UP_MU;
          1:       b = CODE_UP_NU;
          2:       b = CODE_LO_MU;
          default: b = CODE_LO_NU;
        endcase
      end else if (pick < 42) begin
        case ($urandom_range(0, 3))
          0:       b = CODE_UP_PI;
          1:       b = CODE_LO_PI;
          2:       b = CODE_UP_TAU;
          default: b = CODE_LO_TAU;
        endcase
      end else if (pick < 80) begin
        b = 8'($urandom_range(182, 254));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      last = ($urandom_range(0, 9) == 0);
      send_byte(b, last);
    end
    steady = 1'b0;
    push <= 1'b0;

    // drain: everything predicted must come out, then a short quiet spell
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && chars_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> greek_to_latin_transliterator.f
hdl/gtl_pkg.sv
hdl/gtl_front.sv
hdl/gtl_runq.sv
hdl/gtl_back.sv
hdl/greek_to_latin_transliterator.sv
tb/sv/gtl_transliteration_checker.sv
tb/sv/tb_top.sv
